// ----- hw/rtl/topic_filter_wildcard_match_top_defines.svh -----
// Assertion macros for the topic filter matcher checker.
`ifndef TOPIC_FILTER_WILDCARD_MATCH_TOP_DEFINES_SVH
`define TOPIC_FILTER_WILDCARD_MATCH_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define TFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define TFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset.
`define TFM_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tfm_pkg.sv -----
// Shared constants for the topic filter matcher.
`default_nettype none

package tfm_pkg;

  // Default sizing
  localparam int unsigned FILTER_BYTES_DEF  = 256;
  localparam int unsigned SEGMENT_LIMIT_DEF = 32;

  // Filter bytes looked at per topic byte, starting at the current position
  localparam int unsigned LOOK = 6;

  // Characters with meaning in a topic or filter
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // Transaction kinds on the input channel
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_TOPIC  = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/tfm_in_if.sv -----
// Input channel: filter or topic bytes with valid/ready handshake.
`default_nettype none

interface tfm_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, action, data_byte, last, input ready);
  modport sink   (input valid, action, data_byte, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tfm_out_if.sv -----
// Result channel: match verdict with valid/ready handshake.
`default_nettype none

interface tfm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic filter_truncated;

  modport source (output valid, matched, filter_truncated, input ready);
  modport sink   (input valid, matched, filter_truncated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tfm_ram.sv -----
// Generic RAM: one write port, two registered write-first read ports.
`default_nettype none

module tfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_a_r,
  output logic      [WIDTH-1:0] rd_data_b_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read with the new data forwarded on an address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a_r <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
    rd_data_b_r <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/topic_filter_wildcard_match_top.sv -----
// Top level of the topic filter matcher with '+' and '#' wildcards.
//
// Usage: one byte per transaction on in_ch. action = 0 loads a filter byte; the
// byte with last = 1 closes the filter and the next filter byte starts a new one.
// action = 1 streams a topic byte; the topic byte with last = 1 yields one result
// on out_ch (matched, filter_truncated). Filter bytes past FILTER_BYTES are
// dropped and set filter_truncated on later results.
// Throughput: one byte per cycle, filter or topic, with no gaps between topics,
// while no result is stalled on out_ch. The last topic byte goes to the input
// register, then its verdict to the result register, which drives out_ch.valid.
// Each topic byte looks at six filter bytes from the current filter position;
// three dual-read copies of the filter store are addressed with the next
// position so the bytes are ready when the following byte sits in the input
// register.
// Reset: empty filter (never matches), no pending result, in_ch ready.
// Stall: while a result waits on out_ch, in_ch can still fill an empty input
// register; that byte is held and in_ch.ready is low until the result is taken.
`default_nettype none

module topic_filter_wildcard_match_top #(
  parameter int unsigned FILTER_BYTES  = tfm_pkg::FILTER_BYTES_DEF,
  parameter int unsigned SEGMENT_LIMIT = tfm_pkg::SEGMENT_LIMIT_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tfm_in_if.sink    in_ch,
  tfm_out_if.source out_ch
);

  import tfm_pkg::*;

  localparam int unsigned AW = $clog2(FILTER_BYTES);
  localparam int unsigned PW = $clog2(FILTER_BYTES + 1);
  localparam int unsigned EW = PW + 3;
  localparam int unsigned SW = $clog2(SEGMENT_LIMIT + 1);
  localparam logic [SW-1:0] CNT_TOP = SW'(SEGMENT_LIMIT - 1);
  localparam int unsigned NRAM = LOOK / 2;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_LITERAL,
    MODE_ANY,
    MODE_HIT,
    MODE_MISS
  } mode_t;

  // Input register
  logic       stg_valid_r;
  logic       stg_action_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;

  // Result register
  logic out_valid_r, out_valid_nxt;
  logic out_matched_r, out_matched_nxt;
  logic out_trunc_r, out_trunc_nxt;

  // Filter and match state
  logic [PW-1:0] flen_r, flen_nxt;
  logic          fcut_r, fcut_nxt;
  logic          fdone_r, fdone_nxt;
  logic [PW-1:0] fpos_r, fpos_nxt;
  mode_t         mode_r, mode_nxt;
  logic [SW-1:0] tcnt_r, tcnt_nxt;

  // Filter store ports
  logic          ram_we;
  logic [AW-1:0] ram_wr_addr;
  logic [AW-1:0] rd_addr [LOOK];
  logic [7:0]    la_byte [LOOK];

  // Lookahead decode of the filter bytes at the current position
  logic la_vld  [LOOK];
  logic la_bnd  [LOOK];
  logic la_hash [LOOK-1];
  logic la_plus [LOOK-1];

  logic advance;
  logic fire;

  // Pipeline control: only a stalled result holds things up
  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = stg_valid_r && advance;
  assign in_ch.ready = !stg_valid_r || advance;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.matched          = out_matched_r;
  assign out_ch.filter_truncated = out_trunc_r;

  // Per-offset flags: in range, segment boundary, single-character wildcard
  always_comb begin
    for (int k = 0; k < LOOK; k++) begin
      la_vld[k] = (EW'(fpos_r) + EW'(k)) < EW'(flen_r);
      la_bnd[k] = !la_vld[k] || la_byte[k] == CH_SLASH;
    end
    for (int k = 0; k < LOOK - 1; k++) begin
      la_hash[k] = la_vld[k] && la_byte[k] == CH_HASH && la_bnd[k+1];
      la_plus[k] = la_vld[k] && la_byte[k] == CH_PLUS && la_bnd[k+1];
    end
  end

  // Next state for one transaction in the input register
  always_comb begin
    logic [PW-1:0] flen_eff;
    mode_t         m;
    logic [2:0]    off;
    logic [2:0]    off1;
    logic [SW-1:0] cnt;
    logic          verdict;

    flen_eff        = fdone_r ? '0 : flen_r;
    m               = mode_r;
    off             = '0;
    off1            = '0;
    cnt             = tcnt_r;
    verdict         = 1'b0;
    flen_nxt        = flen_r;
    fcut_nxt        = fcut_r;
    fdone_nxt       = fdone_r;
    fpos_nxt        = fpos_r;
    mode_nxt        = mode_r;
    tcnt_nxt        = tcnt_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_matched_nxt = out_matched_r;
    out_trunc_nxt   = out_trunc_r;
    ram_we          = 1'b0;
    ram_wr_addr     = flen_eff[AW-1:0];

    if (fire) begin
      if (stg_action_r == ACT_FILTER) begin
        // Filter byte: abandon any topic, append or flag overflow
        fpos_nxt = '0;
        mode_nxt = MODE_START;
        tcnt_nxt = '0;
        if (fdone_r) begin
          fcut_nxt  = 1'b0;
          fdone_nxt = 1'b0;
        end
        if (flen_eff < PW'(FILTER_BYTES)) begin
          ram_we   = 1'b1;
          flen_nxt = flen_eff + PW'(1);
        end else begin
          fcut_nxt = 1'b1;
        end
        if (stg_last_r) begin
          fdone_nxt = 1'b1;
        end
      end else begin
        fdone_nxt = 1'b1;

        // Segment start: classify the filter segment
        if (m == MODE_START) begin
          if (la_hash[off]) begin
            m = MODE_HIT;
          end else if (la_plus[off]) begin
            m   = MODE_ANY;
            off = off + 3'd1;
          end else begin
            m = MODE_LITERAL;
          end
        end

        // Literal byte compare
        if (stg_byte_r != CH_SLASH && m == MODE_LITERAL) begin
          if (la_vld[off] && la_byte[off] == stg_byte_r) begin
            off = off + 3'd1;
          end else begin
            m = MODE_MISS;
          end
        end

        // Topic segment closed by a slash
        if (stg_byte_r == CH_SLASH && (m == MODE_LITERAL || m == MODE_ANY)) begin
          if (!la_bnd[off]) begin
            m = MODE_MISS;
          end else if (cnt >= CNT_TOP) begin
            m = MODE_HIT;
          end else if (!la_vld[off]) begin
            m = MODE_MISS;
          end else begin
            off = off + 3'd1;
            cnt = cnt + SW'(1);
            m   = MODE_START;
          end
        end

        if (stg_last_r) begin
          // Final segment: classify if fresh, then decide
          if (m == MODE_START) begin
            if (la_hash[off]) begin
              m = MODE_HIT;
            end else if (la_plus[off]) begin
              m   = MODE_ANY;
              off = off + 3'd1;
            end else begin
              m = MODE_LITERAL;
            end
          end
          off1 = off + 3'd1;
          case (m)
            MODE_HIT:  verdict = 1'b1;
            MODE_MISS: verdict = 1'b0;
            default: begin
              if (!la_bnd[off]) begin
                verdict = 1'b0;
              end else if (!la_vld[off]) begin
                verdict = 1'b1;
              end else if (cnt >= CNT_TOP) begin
                verdict = 1'b1;
              end else begin
                verdict = la_hash[off1];
              end
            end
          endcase
          out_valid_nxt   = 1'b1;
          out_matched_nxt = verdict;
          out_trunc_nxt   = fcut_r;
          fpos_nxt        = '0;
          mode_nxt        = MODE_START;
          tcnt_nxt        = '0;
        end else begin
          fpos_nxt = fpos_r + PW'(off);
          mode_nxt = m;
          tcnt_nxt = cnt;
        end
      end
    end
  end

  // Read addresses follow the next position; out-of-range reads are ignored
  always_comb begin
    logic [EW-1:0] pos;
    for (int k = 0; k < LOOK; k++) begin
      pos        = EW'(fpos_nxt) + EW'(k);
      rd_addr[k] = (pos < EW'(FILTER_BYTES)) ? pos[AW-1:0] : '0;
    end
  end

  // Filter store copies, two lookahead offsets each
  for (genvar i = 0; i < NRAM; i++) begin : g_store
    tfm_ram #(
      .WIDTH (8),
      .DEPTH (FILTER_BYTES)
    ) u_store (
      .clk         (clk),
      .wr_en       (ram_we),
      .wr_addr     (ram_wr_addr),
      .wr_data     (stg_byte_r),
      .rd_addr_a   (rd_addr[2*i]),
      .rd_addr_b   (rd_addr[2*i+1]),
      .rd_data_a_r (la_byte[2*i]),
      .rd_data_b_r (la_byte[2*i+1])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      flen_r      <= '0;
      fcut_r      <= 1'b0;
      fdone_r     <= 1'b1;
      fpos_r      <= '0;
      mode_r      <= MODE_START;
      tcnt_r      <= '0;
    end else begin
      if (in_ch.ready) begin
        stg_valid_r <= in_ch.valid;
      end
      out_valid_r <= out_valid_nxt;
      flen_r      <= flen_nxt;
      fcut_r      <= fcut_nxt;
      fdone_r     <= fdone_nxt;
      fpos_r      <= fpos_nxt;
      mode_r      <= mode_nxt;
      tcnt_r      <= tcnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_action_r <= in_ch.action;
      stg_byte_r   <= in_ch.data_byte;
      stg_last_r   <= in_ch.last;
    end
    out_matched_r <= out_matched_nxt;
    out_trunc_r   <= out_trunc_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tfm_checker.sv -----
// Port-level checker for the topic filter matcher, bound to the top level.
`default_nettype none
`include "topic_filter_wildcard_match_top_defines.svh"

module tfm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_matched,
  input wire logic out_truncated
);

  // A stalled result stays offered
  `TFM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its value
  `TFM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_matched) && $stable(out_truncated), "result changed while stalled")

  // Only a pending result may block the input side
  `TFM_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input blocked with no pending result")

  // Reset clears the result register
  `TFM_ASSERT_NEXT_ALWAYS(a_reset_clear, !rst_n, !out_valid, "result valid after reset")

endmodule

bind topic_filter_wildcard_match_top tfm_checker u_tfm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_matched   (out_ch.matched),
  .out_truncated (out_ch.filter_truncated)
);

`default_nettype wire

// ----- test/topic_filter_wildcard_match_top_tb.sv -----
// Self-checking testbench for the topic filter matcher: directed and random byte streams.

module topic_filter_wildcard_match_top_tb;
  import tfm_pkg::*;

  localparam int unsigned FB = FILTER_BYTES_DEF;
  localparam int unsigned SL = SEGMENT_LIMIT_DEF;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PCT = 31;

  typedef enum logic [2:0] {SEG_START, SEG_LITERAL, SEG_ANY, SEG_HIT, SEG_MISS} seg_mode_t;

  typedef struct packed {
    logic matched;
    logic truncated;
  } verdict_t;

  // Tracks the stored filter and the walk through it, queues expected verdicts
  class match_scoreboard;
    logic [7:0]  fstore [FB];
    int unsigned flen;
    int unsigned fpos;
    int unsigned tseg;
    bit          fcut;
    bit          fdone;
    seg_mode_t   mode;
    verdict_t    verdict_q[$];
    int unsigned errors;

    function new();
      flen = 0;
      fcut = 1'b0;
      fdone = 1'b1;
      errors = 0;
      restart();
    endfunction

    function void restart();
      fpos = 0;
      tseg = 0;
      mode = SEG_START;
    endfunction

    function bit fbyte_is(int unsigned p, logic [7:0] ch);
      return p < flen && p < FB && fstore[p] == ch;
    endfunction

    function bit boundary(int unsigned p);
      return p >= flen || p >= FB || fstore[p] == CH_SLASH;
    endfunction

    // Segment made of just this one character
    function bit lone(int unsigned p, logic [7:0] ch);
      return fbyte_is(p, ch) && boundary(p + 1);
    endfunction

    function void classify();
      if (lone(fpos, CH_HASH)) begin
        mode = SEG_HIT;
      end else if (lone(fpos, CH_PLUS)) begin
        mode = SEG_ANY;
        fpos = fpos + 1;
      end else begin
        mode = SEG_LITERAL;
      end
    endfunction

    // Topic segment closed by a slash
    function void close_more();
      if (!boundary(fpos)) begin
        mode = SEG_MISS;
      end else if (tseg + 1 >= SL) begin
        mode = SEG_HIT;
      end else if (fpos >= flen) begin
        mode = SEG_MISS;
      end else begin
        fpos = fpos + 1;
        tseg = tseg + 1;
        mode = SEG_START;
      end
    endfunction

    // Topic closed by its last byte
    function bit close_last();
      if (!boundary(fpos)) return 1'b0;
      if (fpos >= flen) return 1'b1;
      if (tseg + 1 >= SL) return 1'b1;
      return lone(fpos + 1, CH_HASH);
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    // Accepted input transaction
    function void take_byte(logic act, logic [7:0] b, logic lst);
      verdict_t v;
      if (act == ACT_FILTER) begin
        restart();
        if (fdone) begin
          flen = 0;
          fcut = 1'b0;
          fdone = 1'b0;
        end
        if (flen < FB) begin
          fstore[flen] = b;
          flen = flen + 1;
        end else begin
          fcut = 1'b1;
        end
        if (lst) fdone = 1'b1;
        return;
      end
      fdone = 1'b1;
      if (mode == SEG_START) classify();
      if (b != CH_SLASH && mode == SEG_LITERAL) begin
        if (fbyte_is(fpos, b)) fpos = fpos + 1;
        else mode = SEG_MISS;
      end
      if (b == CH_SLASH && (mode == SEG_LITERAL || mode == SEG_ANY)) close_more();
      if (!lst) return;
      if (mode == SEG_START) classify();
      case (mode)
        SEG_HIT:  v.matched = 1'b1;
        SEG_MISS: v.matched = 1'b0;
        default:  v.matched = close_last();
      endcase
      v.truncated = fcut;
      verdict_q.push_back(v);
      restart();
    endfunction

    // Accepted result transaction
    function void check_verdict(logic m, logic t);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result matched=%b filter_truncated=%b", $time, m, t);
        return;
      end
      want = verdict_q.pop_front();
      if (m !== want.matched) begin
        errors++;
        $display("%0t: matched expected %b actual %b", $time, want.matched, m);
      end
      if (t !== want.truncated) begin
        errors++;
        $display("%0t: filter_truncated expected %b actual %b", $time, want.truncated, t);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tfm_in_if  in_ch();
  tfm_out_if out_ch();

  topic_filter_wildcard_match_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  match_scoreboard board;
  int unsigned items_sent;
  int unsigned cycles;
  bit          calm;
  bit          need_filter;
  bit          long_pending;
  bit          short_topics;
  logic [7:0]  fq[$];
  logic [7:0]  tq[$];

  // Clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // No idling on either side through the middle of the random part
  always @(posedge clk) calm <= items_sent >= 600 && items_sent < 800;

  // Offer one byte, wait for the transaction, then predict
  task automatic send_byte(logic act, logic [7:0] b, logic lst);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= b;
    in_ch.last      <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.take_byte(act, b, lst);
    items_sent++;
  endtask

  task automatic send_text(logic act, string s, logic end_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(act, s[i], end_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return "a";
    if (r < 75) return "b";
    if (r < 82) return CH_PLUS;
    if (r < 88) return CH_HASH;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] plain_char();
    return $urandom_range(1) ? 8'("a") : 8'("b");
  endfunction

  task automatic run_directed();
    send_text(ACT_TOPIC, "a", 1'b1);          // empty filter after reset
    send_text(ACT_FILTER, "+/#", 1'b1);
    send_text(ACT_TOPIC, "/", 1'b1);          // empty segments, hash after
    send_text(ACT_TOPIC, "x", 1'b1);          // hash matching nothing more
    send_text(ACT_FILTER, "a/", 1'b1);        // trailing slash
    send_text(ACT_TOPIC, "a/", 1'b1);
    send_byte(ACT_FILTER, 8'hFF, 1'b1);
    send_byte(ACT_TOPIC, 8'hFF, 1'b1);
    send_byte(ACT_TOPIC, 8'h00, 1'b1);
    send_text(ACT_FILTER, "b", 1'b0);         // topic byte closes the load
    send_text(ACT_TOPIC, "b", 1'b1);
    send_text(ACT_FILTER, "c", 1'b1);
    send_text(ACT_TOPIC, "c", 1'b0);          // filter byte abandons the topic
    send_byte(ACT_FILTER, CH_HASH, 1'b1);
    send_byte(ACT_TOPIC, 8'h00, 1'b1);
  endtask

  // Random well-formed filter, occasionally past capacity
  task automatic load_filter();
    int unsigned nseg;
    int unsigned k;
    int unsigned len;
    bit long_one;
    long_one = long_pending || $urandom_range(199) == 0;
    long_pending = 1'b0;
    fq.delete();
    nseg = ($urandom_range(9) == 0) ? $urandom_range(30, 35) : $urandom_range(1, 5);
    for (int s = 0; s < nseg; s++) begin
      if (s > 0) fq.push_back(CH_SLASH);
      k = $urandom_range(99);
      if (k < 15) begin
        fq.push_back(CH_PLUS);
      end else if (k < 25) begin
        fq.push_back(CH_HASH);
      end else if (k >= 30) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) fq.push_back(rand_char());
      end
    end
    if (long_one) begin
      len = FB + $urandom_range(1, 6);
      while (fq.size() < len) fq.push_back("a");
    end
    short_topics = long_one;
    for (int i = 0; i < fq.size(); i++)
      send_byte(ACT_FILTER, fq[i], i == fq.size() - 1);
    need_filter = 1'b0;
  endtask

  // Topic from random segments
  task automatic random_topic();
    int unsigned nseg;
    int unsigned len;
    tq.delete();
    nseg = ($urandom_range(9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      if (s > 0) tq.push_back(CH_SLASH);
      len = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) tq.push_back(rand_char());
    end
  endtask

  // Topic that follows the filter, wildcards filled in, sometimes damaged
  task automatic derived_topic();
    logic [7:0] seg[$];
    int unsigned n;
    int unsigned idx;
    tq.delete();
    for (int i = 0; i <= fq.size(); i++) begin
      if (i == fq.size() || fq[i] == CH_SLASH) begin
        if (seg.size() == 1 && seg[0] == CH_PLUS) begin
          n = $urandom_range(0, 2);
          for (int j = 0; j < n; j++) tq.push_back(plain_char());
        end else if (seg.size() == 1 && seg[0] == CH_HASH) begin
          n = $urandom_range(0, 2);
          if (n == 0 && tq.size() > 0 && tq[tq.size() - 1] == CH_SLASH) void'(tq.pop_back());
          for (int j = 0; j < n; j++) begin
            if (j > 0) tq.push_back(CH_SLASH);
            tq.push_back(plain_char());
          end
        end else begin
          foreach (seg[j]) tq.push_back(seg[j]);
        end
        if (i < fq.size()) tq.push_back(CH_SLASH);
        seg.delete();
      end else begin
        seg.push_back(fq[i]);
      end
    end
    if ($urandom_range(99) < 30 && tq.size() > 0) begin
      idx = $urandom_range(tq.size() - 1);
      case ($urandom_range(2))
        0: tq[idx] = rand_char();
        1: tq.push_back(rand_char());
        default: if (tq.size() > 1) void'(tq.pop_back());
      endcase
    end
    if (tq.size() == 0) tq.push_back(plain_char());
  endtask

  task automatic run_sequence();
    int unsigned ntop;
    int unsigned n;
    if ($urandom_range(99) < 8) begin
      // Broken streams: random kinds, bytes and last flags
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        send_byte(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      need_filter = 1'b1;
      return;
    end
    if (need_filter || $urandom_range(99) < 55) load_filter();
    ntop = $urandom_range(1, 3);
    for (int t = 0; t < ntop; t++) begin
      if (short_topics || $urandom_range(9) == 0) random_topic();
      else derived_topic();
      for (int i = 0; i < tq.size(); i++)
        send_byte(ACT_TOPIC, tq[i], i == tq.size() - 1);
    end
  endtask

  // Result side: check, then choose ready with random stalls and one long hold-off
  initial begin
    int unsigned hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_verdict(out_ch.matched, out_ch.filter_truncated);
      if (!held && items_sent >= 300) begin
        held = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    board = new();
    items_sent = 0;
    need_filter = 1'b1;
    long_pending = 1'b1;
    short_topics = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_FILTER;
    in_ch.data_byte <= 8'h00;
    in_ch.last      <= 1'b0;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    while (items_sent < RANDOM_ITEMS) run_sequence();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tfm_pkg.sv
hw/rtl/tfm_in_if.sv
hw/rtl/tfm_out_if.sv
hw/rtl/tfm_ram.sv
hw/rtl/topic_filter_wildcard_match_top.sv
hw/rtl/tfm_checker.sv
test/topic_filter_wildcard_match_top_tb.sv
